// ----- sv/rau_pkg.sv -----
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] MUL_SEL_NUM0 = 2'd0;
    localparam logic [1:0] MUL_SEL_NUM1 = 2'd1;
    localparam logic [1:0] MUL_SEL_DEN  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       combine;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_step;
        logic       store_n;
        logic       emit;
        status_t    emit_code;
    } cmd_t;

    typedef struct packed {
        logic zero_den;
        logic div_zero;
        logic n_zero;
        logic gcd_done;
    } sts_t;

endpackage

// ----- sv/rau_datapath.sv -----
module rau_datapath
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] lhs_num,
    input  logic signed [31:0] lhs_den,
    input  logic signed [31:0] rhs_num,
    input  logic signed [31:0] rhs_den,
    output logic               done,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int KW = $clog2(PW + 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

    logic [2:0]    op_reg;
    logic [W-1:0]  ln_reg, ld_reg, rn_reg, rd_reg;
    logic          lns_reg, lds_reg, rns_reg, rds_reg;
    logic [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic          p0s_reg, p1s_reg, p2s_reg;
    logic [PW-1:0] n_reg, d_reg;
    logic          ns_reg, ds_reg;
    logic [PW-1:0] a_reg, b_reg, g_reg, q_reg, r_reg, nm_reg;
    logic [KW-1:0] k_reg;
    logic          done_reg;
    logic [31:0]   num_reg;
    logic [30:0]   den_reg;
    status_t       status_reg;

    logic [W-1:0]  ln_v, ld_v, rn_v, rd_v;
    logic [W-1:0]  ma, mb;
    logic          mneg;
    logic [PW-1:0] prod;
    logic [PW-1:0] sum;
    logic          sum_neg;
    logic [PW-1:0] n_next, d_next;
    logic          ns_next, ds_next;
    logic [PW:0]   div_try;
    logic          div_ge;
    logic          res_neg, ovf;
    logic [31:0]   mag32;

    assign ln_v = lhs_num[W-1:0];
    assign ld_v = lhs_den[W-1:0];
    assign rn_v = rhs_num[W-1:0];
    assign rd_v = rhs_den[W-1:0];

    // The shared multiplier takes one product per cycle.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEL_NUM0:
            begin
                ma   = ln_reg;
                mb   = (op_reg == OP_MUL) ? rn_reg : rd_reg;
                mneg = lns_reg ^ ((op_reg == OP_MUL) ? rns_reg : rds_reg);
            end
            MUL_SEL_NUM1:
            begin
                ma   = rn_reg;
                mb   = ld_reg;
                mneg = rns_reg ^ (op_reg == OP_SUB) ^ lds_reg;
            end
            default:
            begin
                ma   = ld_reg;
                mb   = (op_reg == OP_DIV) ? rn_reg : rd_reg;
                mneg = lds_reg ^ ((op_reg == OP_DIV) ? rns_reg : rds_reg);
            end
        endcase
        prod = PW'(ma) * PW'(mb);
    end

    // Signed-magnitude sum of the two cross products; zero products carry a don't-care sign.
    always_comb
    begin
        if (p0s_reg == p1s_reg)
        begin
            sum     = p0_reg + p1_reg;
            sum_neg = p0s_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum     = p0_reg - p1_reg;
            sum_neg = p0s_reg;
        end
        else
        begin
            sum     = p1_reg - p0_reg;
            sum_neg = p1s_reg;
        end

        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                n_next  = sum;
                ns_next = sum_neg;
            end
            OP_MUL, OP_DIV:
            begin
                n_next  = p0_reg;
                ns_next = p0s_reg;
            end
            default:
            begin
                n_next  = PW'(ln_reg);
                ns_next = lns_reg;
            end
        endcase
        if (op_reg <= OP_DIV)
        begin
            d_next  = p2_reg;
            ds_next = p2s_reg;
        end
        else
        begin
            d_next  = PW'(ld_reg);
            ds_next = lds_reg;
        end
    end

    assign div_try = {r_reg, q_reg[PW-1]};
    assign div_ge  = div_try >= {1'b0, g_reg};

    always_comb
    begin
        res_neg = ns_reg ^ ds_reg;
        ovf     = (q_reg > HALF - PW'(1)) ||
                  (res_neg ? (nm_reg > HALF) : (nm_reg > HALF - PW'(1)));
        mag32   = 32'(nm_reg);
    end

    always_comb
    begin
        sts.zero_den = (ld_reg == '0) || ((op_reg <= OP_DIV) && (rd_reg == '0));
        sts.div_zero = (op_reg == OP_DIV) && (rn_reg == '0);
        sts.n_zero   = (n_reg == '0);
        sts.gcd_done = (a_reg == '0) || (b_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            lns_reg <= ln_v[W-1];
            lds_reg <= ld_v[W-1];
            rns_reg <= rn_v[W-1];
            rds_reg <= rd_v[W-1];
            ln_reg  <= ln_v[W-1] ? (W'(0) - ln_v) : ln_v;
            ld_reg  <= ld_v[W-1] ? (W'(0) - ld_v) : ld_v;
            rn_reg  <= rn_v[W-1] ? (W'(0) - rn_v) : rn_v;
            rd_reg  <= rd_v[W-1] ? (W'(0) - rd_v) : rd_v;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_SEL_NUM0:
                begin
                    p0_reg  <= prod;
                    p0s_reg <= mneg;
                end
                MUL_SEL_NUM1:
                begin
                    p1_reg  <= prod;
                    p1s_reg <= mneg;
                end
                default:
                begin
                    p2_reg  <= prod;
                    p2s_reg <= mneg;
                end
            endcase
        end
        if (cmd.combine)
        begin
            n_reg  <= n_next;
            ns_reg <= ns_next;
            d_reg  <= d_next;
            ds_reg <= ds_next;
            a_reg  <= n_next;
            b_reg  <= d_next;
            k_reg  <= '0;
        end
        // Binary GCD: common factors of two are counted in k and restored at the end.
        if (cmd.gcd_step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
        if (cmd.gcd_fin)
        begin
            g_reg <= (a_reg | b_reg) << k_reg;
            q_reg <= n_reg;
            r_reg <= '0;
        end
        // Restoring division, one quotient bit per cycle.
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                r_reg <= PW'(div_try - {1'b0, g_reg});
                q_reg <= {q_reg[PW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= div_try[PW-1:0];
                q_reg <= {q_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.store_n)
        begin
            nm_reg <= q_reg;
            q_reg  <= d_reg;
            r_reg  <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            num_reg    <= '0;
            den_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                if (cmd.emit_code != ST_OK)
                begin
                    num_reg    <= '0;
                    den_reg    <= '0;
                    status_reg <= cmd.emit_code;
                end
                else if (sts.n_zero)
                begin
                    num_reg    <= '0;
                    den_reg    <= 31'd1;
                    status_reg <= ST_OK;
                end
                else if (ovf)
                begin
                    num_reg    <= '0;
                    den_reg    <= '0;
                    status_reg <= ST_OVERFLOW;
                end
                else
                begin
                    num_reg    <= res_neg ? (32'd0 - mag32) : mag32;
                    den_reg    <= 31'(q_reg);
                    status_reg <= ST_OK;
                end
            end
        end
    end

    assign done    = done_reg;
    assign res_num = num_reg;
    assign res_den = den_reg;
    assign status  = status_reg;

endmodule

// ----- sv/rau_ctrl.sv -----
module rau_ctrl
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int PW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(PW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_ZCHK,
        S_GCD,
        S_GFIN,
        S_DIVN,
        S_NSTORE,
        S_DIVD,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    status_t       code_reg, code_next;
    logic          cnt_last;

    assign cnt_last = (cnt_reg == CW'(PW - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.emit_code = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    code_next  = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.zero_den)
                begin
                    code_next  = ST_ZERO_DEN;
                    state_next = S_EMIT;
                end
                else if (sts.div_zero)
                begin
                    code_next  = ST_DIV_ZERO;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_NUM0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_NUM1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEL_DEN;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = S_ZCHK;
            end
            S_ZCHK:
            begin
                state_next = sts.n_zero ? S_EMIT : S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = S_GFIN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_GFIN:
            begin
                cmd.gcd_fin = 1'b1;
                cnt_next    = '0;
                state_next  = S_DIVN;
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    state_next = S_NSTORE;
                end
            end
            S_NSTORE:
            begin
                cmd.store_n = 1'b1;
                cnt_next    = '0;
                state_next  = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Sequence: a zero-denominator or division-by-zero beat goes from the input check straight to
// the result; a zero result skips the GCD and the divisions; otherwise the binary GCD runs,
// then two bit-serial divisions by the GCD, the numerator first and then the denominator.
// Throughput: one beat at a time; start is taken again in the cycle done is high.
// done is high for one cycle with the result, which then holds until the next beat ends; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) returns the controller to idle and clears done.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] lhs_num,
    input  logic signed [31:0] lhs_den,
    input  logic signed [31:0] rhs_num,
    input  logic signed [31:0] rhs_den,
    output logic               done,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);

    cmd_t cmd;
    sts_t sts;

    rau_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req_type (req_type),
        .lhs_num  (lhs_num),
        .lhs_den  (lhs_den),
        .rhs_num  (rhs_num),
        .rhs_den  (rhs_den),
        .done     (done),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

endmodule

// ----- sv/rau_checker.sv -----
module rau_checker
    import rau_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] res_num,
    input logic [30:0]        res_den,
    input logic [1:0]         status
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a beat in progress");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (res_num == 0) && (res_den == 0))
        else $error("error result carries a nonzero fraction");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OK) |-> (res_den != 0))
        else $error("good result with zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .res_num (res_num),
    .res_den (res_den),
    .status  (status)
);
